// File: design/vertex_id_compaction_core_macros.svh
// ----------------------------------------------------------------------------
// vertex_id_compaction_core_macros
// Assertion helpers used by the vertex id compaction core.
// ----------------------------------------------------------------------------
`ifndef VERTEX_ID_COMPACTION_CORE_MACROS_SVH
`define VERTEX_ID_COMPACTION_CORE_MACROS_SVH

// same-cycle implication
`define VIDC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vertex id compaction: check failed");

// next-cycle implication
`define VIDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vertex id compaction: check failed");

`endif

// File: design/vidc_pkg.sv
// ----------------------------------------------------------------------------
// vidc_pkg
// Shared types and fixed field widths for the vertex id compaction core.
// ----------------------------------------------------------------------------
package vidc_pkg;

    localparam int unsigned ID_IN_W = 17;
    localparam int unsigned RANK_W  = 16;
    localparam int unsigned CNT_W   = 17;

    typedef enum logic [1:0] {
        ACT_MARK   = 2'd0,
        ACT_FINISH = 2'd1,
        ACT_XLATE  = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_MARK2,
        S_FIN,
        S_FIN_DRAIN,
        S_CLEAR,
        S_EMIT
    } state_t;

endpackage

// File: design/vidc_req_if.sv
// ----------------------------------------------------------------------------
// vidc_req_if
// Request channel: one edge or command per transaction.
// ----------------------------------------------------------------------------
interface vidc_req_if;
    import vidc_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [ID_IN_W-1:0] src_id;
    logic [ID_IN_W-1:0] dst_id;

    modport source (output valid, output action, output src_id, output dst_id, input ready);
    modport sink   (input valid, input action, input src_id, input dst_id, output ready);
endinterface

// File: design/vidc_rsp_if.sv
// ----------------------------------------------------------------------------
// vidc_rsp_if
// Result channel: ranks, vertex count and error flag.
// ----------------------------------------------------------------------------
interface vidc_rsp_if;
    import vidc_pkg::*;

    logic              valid;
    logic              ready;
    logic [RANK_W-1:0] new_src;
    logic [RANK_W-1:0] new_dst;
    logic [CNT_W-1:0]  vertex_count;
    logic              id_error;

    modport source (output valid, output new_src, output new_dst, output vertex_count,
                    output id_error, input ready);
    modport sink   (input valid, input new_src, input new_dst, input vertex_count,
                    input id_error, output ready);
endinterface

// File: design/vidc_cfg_if.sv
// ----------------------------------------------------------------------------
// vidc_cfg_if
// Configuration write channel for the one-based id register.
// ----------------------------------------------------------------------------
interface vidc_cfg_if;
    logic valid;
    logic ready;
    logic one_based_ids;

    modport source (output valid, output one_based_ids, input ready);
    modport sink   (input valid, input one_based_ids, output ready);
endinterface

// File: design/vertex_id_compaction_core.sv
// ----------------------------------------------------------------------------
// vertex_id_compaction_core
// Dense relabelling of graph vertex ids over a used-bit map and a rank table.
// ----------------------------------------------------------------------------
// One transaction at a time. Mark: two writes to the used map (one write
// port). Translate: both ranks read in the same cycle from the dual-read rank
// table, then the result register is loaded. Mark with a bad id: no write, an
// error result. Finish: one used-map entry per cycle, index 0 to largest_id,
// through the read-then-write rank pipeline. Clear: index 0 to largest_id,
// one used-map entry cleared per cycle. After reset the whole used map is swept
// clean before the first request is taken; configuration writes are taken at
// any time. A waiting result stalls completion only, never acceptance of the
// item after it.
// ----------------------------------------------------------------------------
`include "vertex_id_compaction_core_macros.svh"

module vertex_id_compaction_core #(
    parameter int unsigned MAX_VERTICES = 65536
) (
    input  logic             clk,
    input  logic             rst_n,
    vidc_req_if.sink         req,
    vidc_rsp_if.source       rsp,
    vidc_cfg_if.sink         cfg
);
    import vidc_pkg::*;

    localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_VERTICES - 1);

    // memories
    logic              used_mem [MAX_VERTICES];
    logic [RANK_W-1:0] rank_mem [MAX_VERTICES];

    // control
    state_t        state_reg, state_next;
    action_t       action_reg, action_next;
    logic          one_based_reg;
    logic [AW-1:0] largest_reg, largest_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          p_valid_reg, p_valid_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic          rsp_valid_reg, rsp_valid_next;

    // payload
    logic [AW-1:0] d_idx_reg;
    logic          s_ok_reg, d_ok_reg;
    logic [AW-1:0] p_addr_reg;
    logic          used_rd_reg;
    logic [RANK_W-1:0] rank_rd_a_reg, rank_rd_b_reg;
    logic [RANK_W-1:0] new_src_reg, new_dst_reg;
    logic [CNT_W-1:0]  count_out_reg;
    logic          err_out_reg;

    // combinational
    logic          accept;
    logic          slot_free;
    action_t       req_action;
    logic          s_ok, d_ok;
    logic [AW-1:0] s_idx, d_idx;
    logic          used_we, used_wdata, used_re;
    logic [AW-1:0] used_waddr, used_raddr;
    logic          rank_we, rank_re;
    logic [AW-1:0] rank_waddr;
    logic [RANK_W-1:0] rank_wdata;
    logic          load_out;
    logic [RANK_W-1:0] res_src, res_dst;
    logic [CNT_W-1:0]  res_count;
    logic          res_err;

    function automatic logic id_ok(input logic [ID_IN_W-1:0] raw, input logic one_based);
        logic [31:0] v;
        logic        ok;
        v  = 32'(raw);
        ok = 1'b1;
        if (one_based)
        begin
            ok = (raw != '0);
            v  = v - 32'd1;
        end
        return ok && (v < 32'(MAX_VERTICES));
    endfunction

    function automatic logic [AW-1:0] id_index(input logic [ID_IN_W-1:0] raw,
                                                input logic one_based);
        logic [31:0] v;
        v = 32'(raw) - (one_based ? 32'd1 : 32'd0);
        return v[AW-1:0];
    endfunction

    assign req_action = action_t'(req.action);
    assign req.ready  = (state_reg == S_IDLE);
    assign accept     = req.valid && req.ready;
    assign slot_free  = !rsp_valid_reg || rsp.ready;
    assign cfg.ready  = 1'b1;

    assign s_ok  = id_ok(req.src_id, one_based_reg);
    assign d_ok  = id_ok(req.dst_id, one_based_reg);
    assign s_idx = id_index(req.src_id, one_based_reg);
    assign d_idx = id_index(req.dst_id, one_based_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (idx_reg == LAST_IDX)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_action)
                        ACT_MARK:   state_next = (s_ok && d_ok) ? S_MARK2 : S_EMIT;
                        ACT_FINISH: state_next = S_FIN;
                        ACT_XLATE:  state_next = S_EMIT;
                        ACT_CLEAR:  state_next = S_CLEAR;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_MARK2:     state_next = S_IDLE;
            S_FIN:
            begin
                if (idx_reg == largest_reg)
                    state_next = S_FIN_DRAIN;
            end
            S_FIN_DRAIN: state_next = S_EMIT;
            S_CLEAR:
            begin
                if (idx_reg == largest_reg)
                    state_next = S_IDLE;
            end
            S_EMIT:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        action_next    = action_reg;
        largest_next   = largest_reg;
        idx_next       = idx_reg;
        p_valid_next   = 1'b0;
        cnt_next       = cnt_reg;
        used_we        = 1'b0;
        used_wdata     = 1'b0;
        used_waddr     = idx_reg;
        used_re        = 1'b0;
        used_raddr     = idx_reg;
        rank_re        = 1'b0;
        rank_we        = p_valid_reg;
        rank_waddr     = p_addr_reg;
        rank_wdata     = used_rd_reg ? cnt_reg[RANK_W-1:0] : '0;
        load_out       = 1'b0;
        res_src        = '0;
        res_dst        = '0;
        res_count      = '0;
        res_err        = 1'b0;

        if (p_valid_reg)
            cnt_next = cnt_reg + CNT_W'(used_rd_reg);

        case (state_reg)
            S_INIT:
            begin
                used_we  = 1'b1;
                idx_next = idx_reg + AW'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    action_next = req_action;
                    idx_next    = '0;
                    case (req_action)
                        ACT_MARK:
                        begin
                            if (s_ok && d_ok)
                            begin
                                used_we    = 1'b1;
                                used_wdata = 1'b1;
                                used_waddr = s_idx;
                                if ((s_idx > largest_reg) && (s_idx >= d_idx))
                                    largest_next = s_idx;
                                else if (d_idx > largest_reg)
                                    largest_next = d_idx;
                            end
                        end
                        ACT_FINISH: cnt_next = '0;
                        ACT_XLATE:  rank_re  = 1'b1;
                        ACT_CLEAR:  ;
                        default:    ;
                    endcase
                end
            end
            S_MARK2:
            begin
                used_we    = 1'b1;
                used_wdata = 1'b1;
                used_waddr = d_idx_reg;
            end
            S_FIN:
            begin
                used_re      = 1'b1;
                p_valid_next = 1'b1;
                idx_next     = idx_reg + AW'(1);
            end
            S_FIN_DRAIN: ;
            S_CLEAR:
            begin
                used_we  = 1'b1;
                idx_next = idx_reg + AW'(1);
                if (idx_reg == largest_reg)
                    largest_next = '0;
            end
            S_EMIT:
            begin
                load_out = slot_free;
                case (action_reg)
                    ACT_MARK:   res_err = 1'b1;
                    ACT_FINISH: res_count = cnt_reg;
                    ACT_XLATE:
                    begin
                        res_src = s_ok_reg ? rank_rd_a_reg : '0;
                        res_dst = d_ok_reg ? rank_rd_b_reg : '0;
                        res_err = !(s_ok_reg && d_ok_reg);
                    end
                    default:    ;
                endcase
            end
            default: ;
        endcase

        if (load_out)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            action_reg    <= ACT_MARK;
            one_based_reg <= 1'b0;
            largest_reg   <= '0;
            idx_reg       <= '0;
            p_valid_reg   <= 1'b0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            action_reg    <= action_next;
            largest_reg   <= largest_next;
            idx_reg       <= idx_next;
            p_valid_reg   <= p_valid_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg.valid && cfg.ready)
                one_based_reg <= cfg.one_based_ids;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            d_idx_reg <= d_idx;
            s_ok_reg  <= s_ok;
            d_ok_reg  <= d_ok;
        end
        if (used_re)
            p_addr_reg <= used_raddr;
        if (load_out)
        begin
            new_src_reg   <= res_src;
            new_dst_reg   <= res_dst;
            count_out_reg <= res_count;
            err_out_reg   <= res_err;
        end
    end

    // used map
    always_ff @(posedge clk)
    begin
        if (used_we)
            used_mem[used_waddr] <= used_wdata;
        if (used_re)
            used_rd_reg <= used_mem[used_raddr];
    end

    // rank table, one write port and two read ports
    always_ff @(posedge clk)
    begin
        if (rank_we)
            rank_mem[rank_waddr] <= rank_wdata;
        if (rank_re)
        begin
            rank_rd_a_reg <= rank_mem[s_idx];
            rank_rd_b_reg <= rank_mem[d_idx];
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.new_src      = new_src_reg;
    assign rsp.new_dst      = new_dst_reg;
    assign rsp.vertex_count = count_out_reg;
    assign rsp.id_error     = err_out_reg;

    // checks
    `VIDC_ASSERT_IMPLY(a_walk_bound, clk, rst_n, (state_reg == S_FIN), (idx_reg <= largest_reg))
    `VIDC_ASSERT_IMPLY(a_rank_bound, clk, rst_n, p_valid_reg, (32'(cnt_reg) <= 32'(p_addr_reg)))
    `VIDC_ASSERT_NEXT(a_mark_grows, clk, rst_n, accept && (req_action == ACT_MARK),
                      (largest_reg >= $past(largest_reg)))
    `VIDC_ASSERT_NEXT(a_clear_done, clk, rst_n, (state_reg == S_CLEAR) && (idx_reg == largest_reg),
                      (largest_reg == '0))

endmodule
